// ----- src/button_debounce_longpress_fsm_assert.svh -----
// Assertion macros shared by the debounce block.
// No dependencies; included by modules that carry checks.
`ifndef BUTTON_DEBOUNCE_LONGPRESS_FSM_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_FSM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BDLP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdlp assertion failed");

// Next-cycle implication, disabled during reset.
`define BDLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdlp assertion failed");

`endif

// ----- src/bdlp_pkg.sv -----
// Types and constants for the button debouncer with long press and repeat.
// No dependencies.
`timescale 1ns / 1ps

package bdlp_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   // counter loads are masked to the timer width and to the 16-bit state
   localparam int CNT_W       = (TIMER_WIDTH < 16) ? TIMER_WIDTH : 16;

   localparam int CSR_IDX_W   = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_ENABLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_ENABLE     = 2'd3;

   typedef enum logic [2:0] {
      PH_RELEASED    = 3'd0,
      PH_TO_PRESSED  = 3'd1,
      PH_PRESSED     = 3'd2,
      PH_TO_RELEASED = 3'd3,
      PH_LONG        = 3'd4,
      PH_LONG_TO_REL = 3'd5,
      PH_ENTER_REL   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_PRESS      = 3'd1,
      EV_RELEASE    = 3'd2,
      EV_LONG_PRESS = 3'd3,
      EV_LONG_REL   = 3'd4,
      EV_ENTER_REL  = 3'd5,
      EV_REPEAT     = 3'd6
   } event_type;

   typedef struct packed {
      logic [CNT_W-1:0] debounce_ticks;
      logic [CNT_W-1:0] long_press_ticks;
      logic             long_press_enable;
      logic             repeat_enable;
   } cfg_type;

   typedef struct packed {
      event_type ev;
      logic      held;
   } rsp_type;

endpackage

// ----- src/button_debounce_longpress_fsm.sv -----
// Top level of the button debouncer with long press and repeat.
// Depends on bdlp_pkg, bdlp_core and bdlp_rsp_queue.
`timescale 1ns / 1ps
//
// Usage
//  - req channel: one raw button sample (req_level, 1 = pressed) per
//    transaction; a transaction completes when req_valid is high and
//    req_stall is low.
//  - rsp channel: exactly one result per sample: rsp_event_res (0 none,
//    1 press, 2 release, 3 long press, 4 long release, 5 entering released,
//    6 repeat) and rsp_held, the debounced level after that sample.
//  - csr port: csr_we writes csr_wdata into the register at csr_index
//    (0 debounce ticks, 1 long press ticks, 2 long press enable,
//    3 repeat enable). Write only while no results are pending.
//  - Timing: the result is registered in the result queue and offered
//    once earlier results have been taken. Throughput: one sample per
//    cycle while req_stall is low (state and counter update in bdlp_core).
//  - Receiver stall: a two-entry result queue keeps taking samples while
//    a result waits; req_stall rises only when both entries are held.
//  - Reset: synchronous, active high; phase returns to released, the
//    counter to zero, the queue empties and the registers take their
//    defaults (20, 1000, 1, 1).
//
module button_debounce_longpress_fsm import bdlp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // sample channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_level,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_event_res,
   output logic                 rsp_held,
   // configuration write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0] csr_wdata
);

   cfg_type cfg_ff;
   rsp_type core_result;
   rsp_type head_result;
   logic    queue_full;
   logic    accept;

   // advance the machine on every completed sample transaction
   assign accept    = req_valid && !queue_full;
   assign req_stall = queue_full;

   // configuration registers; loads are masked to the counter width here
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks    <= CNT_W'(20);
         cfg_ff.long_press_ticks  <= CNT_W'(1000);
         cfg_ff.long_press_enable <= 1'b1;
         cfg_ff.repeat_enable     <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TICKS:    cfg_ff.debounce_ticks    <= csr_wdata[CNT_W-1:0];
            CSR_LONG_PRESS_TICKS:  cfg_ff.long_press_ticks  <= csr_wdata[CNT_W-1:0];
            CSR_LONG_PRESS_ENABLE: cfg_ff.long_press_enable <= csr_wdata[0];
            CSR_REPEAT_ENABLE:     cfg_ff.repeat_enable     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   bdlp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .level  (req_level),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   // hold results here while the receiver stalls
   bdlp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (head_result)
   );

   assign rsp_event_res = head_result.ev;
   assign rsp_held      = head_result.held;

endmodule

// ----- src/bdlp_core.sv -----
// Debounce state machine and down-counter, advanced once per accepted sample.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_core import bdlp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    level,
   input  cfg_type cfg,
   output rsp_type result
);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   event_type        ev;
   logic             cnt_zero;

   assign cnt_zero = (cnt_ff == '0);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_TO_PRESSED: begin
            if (!level) phase_in = PH_RELEASED;
            else if (cnt_zero) phase_in = PH_PRESSED;
         end
         PH_PRESSED: begin
            if (!level) phase_in = PH_TO_RELEASED;
            else if (cfg.long_press_enable && cnt_zero) phase_in = PH_LONG;
         end
         PH_TO_RELEASED: begin
            if (level) phase_in = PH_PRESSED;
            else if (cnt_zero)
               phase_in = cfg.long_press_enable ? PH_ENTER_REL : PH_RELEASED;
         end
         PH_LONG: begin
            if (!level) phase_in = PH_LONG_TO_REL;
         end
         PH_LONG_TO_REL: begin
            if (level) phase_in = PH_LONG;
            else if (cnt_zero)
               phase_in = cfg.long_press_enable ? PH_ENTER_REL : PH_RELEASED;
         end
         default: begin
            // released, entering released, and the unused code
            phase_in = level ? PH_TO_PRESSED : PH_RELEASED;
         end
      endcase
   end

   // event and counter
   always_comb begin
      ev     = (phase_ff == PH_ENTER_REL) ? EV_ENTER_REL : EV_NONE;
      cnt_in = cnt_ff;
      unique case (phase_ff)
         PH_TO_PRESSED: begin
            if (level) begin
               if (cnt_zero) begin
                  ev = EV_PRESS;
                  if (cfg.long_press_enable) cnt_in = cfg.long_press_ticks;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         PH_PRESSED: begin
            if (!level) begin
               cnt_in = cfg.debounce_ticks;
            end else if (cfg.long_press_enable) begin
               if (cnt_zero) begin
                  ev     = EV_LONG_PRESS;
                  cnt_in = cfg.long_press_ticks;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         PH_TO_RELEASED: begin
            if (!level) begin
               if (cnt_zero) ev = EV_RELEASE;
               else cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         PH_LONG: begin
            if (!level) begin
               cnt_in = cfg.debounce_ticks;
            end else if (cfg.repeat_enable) begin
               if (cnt_zero) begin
                  ev     = EV_REPEAT;
                  cnt_in = cfg.long_press_ticks;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         PH_LONG_TO_REL: begin
            if (!level) begin
               if (cnt_zero) ev = EV_LONG_REL;
               else cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            if (level) cnt_in = cfg.debounce_ticks;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASED;
         cnt_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign result.ev   = ev;
   assign result.held = (phase_in == PH_PRESSED) || (phase_in == PH_TO_RELEASED) ||
                        (phase_in == PH_LONG) || (phase_in == PH_LONG_TO_REL);

endmodule

// ----- src/bdlp_rsp_queue.sv -----
// Two-entry result queue that decouples the sample side from a stalled receiver.
// Depends on bdlp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "button_debounce_longpress_fsm_assert.svh"

module bdlp_rsp_queue import bdlp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   rsp_type    slot_ff [2];
   logic       head_ff, head_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic       tail;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign tail      = head_ff ^ count_ff[0];
   assign rsp_data  = slot_ff[head_ff];

   always_comb begin
      head_in  = pop ? ~head_ff : head_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // payload slots, no reset needed
   always_ff @(posedge clock) begin
      if (push) slot_ff[tail] <= push_data;
   end

   `BDLP_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= 2'd2)
   `BDLP_ASSERT_NOW(a_no_push_full, clock, reset, full, !push)
   `BDLP_ASSERT_NEXT(a_pop_only, clock, reset, pop && !push,
                     count_ff == $past(count_ff) - 2'd1)
   `BDLP_ASSERT_NEXT(a_push_only, clock, reset, push && !pop,
                     count_ff == $past(count_ff) + 2'd1)

endmodule

// ----- tb/button_debounce_longpress_fsm_tb.sv -----
// Self-checking testbench for button_debounce_longpress_fsm: a directed table
// followed by random press/release sequences under several pacing modes.
// Depends on bdlp_pkg and the button_debounce_longpress_fsm RTL.
`timescale 1ns / 1ps

module button_debounce_longpress_fsm_tb;
   import bdlp_pkg::*;

   localparam int QUIET_LIMIT = 3000;   // cycles with no transaction at all
   localparam int PHASE_ITEMS = 118;
   localparam int HUGE_ITEMS  = 40;     // samples in the phase with the largest counter loads
   localparam int SCRIPT_LEN  = 25;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_level = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_event_res;
   logic                 rsp_held;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DEBOUNCE_TICKS;
   logic [CFG_WIDTH-1:0] csr_wdata = '0;

   // Sideband that travels with each sample: when set, the typed-in result
   // replaces the computed one for that transaction.
   logic      pin_valid = 1'b0;
   event_type pin_ev    = EV_NONE;
   logic      pin_held  = 1'b0;

   button_debounce_longpress_fsm DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_level     (req_level),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_event_res (rsp_event_res),
      .rsp_held      (rsp_held),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // ------------------------------------------------------------------
   // Debouncer model: its own copy of the registers and of the machine.
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] mdl_debounce;
   logic [CNT_W-1:0] mdl_long_ticks;
   logic             mdl_long_en;
   logic             mdl_repeat_en;
   phase_type        fsm_phase;
   logic [15:0]      fsm_count;

   rsp_type pending_events[$];   // expected results, oldest first
   rsp_type computed;
   rsp_type oldest;
   int      fail_count = 0;

   // Advance the machine by one raw sample and return the event of that tick.
   function automatic rsp_type advance_debouncer(input logic lvl);
      rsp_type   r;
      phase_type ph;
      r.ev = EV_NONE;
      ph   = fsm_phase;
      // entering released reports its own event, then behaves as released
      if (ph == PH_ENTER_REL) begin
         r.ev = EV_ENTER_REL;
         ph   = PH_RELEASED;
      end
      case (ph)
         PH_TO_PRESSED: begin
            if (!lvl) begin
               ph = PH_RELEASED;
            end else if (fsm_count == '0) begin
               ph   = PH_PRESSED;
               r.ev = EV_PRESS;
               if (mdl_long_en) fsm_count = 16'(mdl_long_ticks);
            end else begin
               fsm_count = fsm_count - 16'd1;
            end
         end
         PH_PRESSED: begin
            if (!lvl) begin
               ph        = PH_TO_RELEASED;
               fsm_count = 16'(mdl_debounce);
            end else if (mdl_long_en) begin
               if (fsm_count == '0) begin
                  ph        = PH_LONG;
                  r.ev      = EV_LONG_PRESS;
                  fsm_count = 16'(mdl_long_ticks);
               end else begin
                  fsm_count = fsm_count - 16'd1;
               end
            end
         end
         PH_TO_RELEASED: begin
            if (lvl) begin
               ph = PH_PRESSED;
            end else if (fsm_count == '0) begin
               ph   = mdl_long_en ? PH_ENTER_REL : PH_RELEASED;
               r.ev = EV_RELEASE;
            end else begin
               fsm_count = fsm_count - 16'd1;
            end
         end
         PH_LONG: begin
            if (!lvl) begin
               ph        = PH_LONG_TO_REL;
               fsm_count = 16'(mdl_debounce);
            end else if (mdl_repeat_en) begin
               if (fsm_count == '0) begin
                  r.ev      = EV_REPEAT;
                  fsm_count = 16'(mdl_long_ticks);
               end else begin
                  fsm_count = fsm_count - 16'd1;
               end
            end
         end
         PH_LONG_TO_REL: begin
            if (lvl) begin
               ph = PH_LONG;
            end else if (fsm_count == '0) begin
               ph   = mdl_long_en ? PH_ENTER_REL : PH_RELEASED;
               r.ev = EV_LONG_REL;
            end else begin
               fsm_count = fsm_count - 16'd1;
            end
         end
         default: begin
            ph = PH_RELEASED;
            if (lvl) begin
               ph        = PH_TO_PRESSED;
               fsm_count = 16'(mdl_debounce);
            end
         end
      endcase
      fsm_phase = ph;
      r.held = (ph == PH_PRESSED) || (ph == PH_TO_RELEASED) ||
               (ph == PH_LONG) || (ph == PH_LONG_TO_REL);
      return r;
   endfunction

   // Track register writes, predict each accepted sample and check each
   // accepted result against the oldest prediction. All signals are
   // sampled at the edge, before the nonblocking updates land.
   always @(posedge clock) begin
      if (reset) begin
         mdl_debounce   = CNT_W'(20);
         mdl_long_ticks = CNT_W'(1000);
         mdl_long_en    = 1'b1;
         mdl_repeat_en  = 1'b1;
         fsm_phase      = PH_RELEASED;
         fsm_count      = '0;
         pending_events.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE_TICKS:    mdl_debounce   = csr_wdata[CNT_W-1:0];
               CSR_LONG_PRESS_TICKS:  mdl_long_ticks = csr_wdata[CNT_W-1:0];
               CSR_LONG_PRESS_ENABLE: mdl_long_en    = csr_wdata[0];
               CSR_REPEAT_ENABLE:     mdl_repeat_en  = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            computed = advance_debouncer(req_level);
            // keep the model stepping; a typed-in row wins
            if (pin_valid) begin
               computed.ev   = pin_ev;
               computed.held = pin_held;
            end
            pending_events.push_back(computed);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               $display("%0t: result with nothing expected: event %0d held %0b",
                        $time, rsp_event_res, rsp_held);
               fail_count++;
            end else begin
               oldest = pending_events.pop_front();
               if (rsp_event_res !== oldest.ev) begin
                  $display("%0t: event mismatch: expected %0d, actual %0d",
                           $time, oldest.ev, rsp_event_res);
                  fail_count++;
               end
               if (rsp_held !== oldest.held) begin
                  $display("%0t: held mismatch: expected %0b, actual %0b",
                           $time, oldest.held, rsp_held);
                  fail_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run as failed if no transaction of any kind
   // happens before the quiet counter reaches QUIET_LIMIT.
   // ------------------------------------------------------------------
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("** button_debounce_longpress_fsm: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------
   // Result side: random stall, or a long hold-off when one is requested.
   // ------------------------------------------------------------------
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;

   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sample side
   // ------------------------------------------------------------------
   int cur_debounce;
   int cur_long_ticks;

   // Offer one sample and hold it until the transaction completes.
   task automatic send_sample(input logic lvl, input logic pin, input event_type ev,
                              input logic hld);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_level <= lvl;
      pin_valid <= pin;
      pin_ev    <= ev;
      pin_held  <= hld;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every expected result has been taken.
   // Step one edge first so the last accepted sample is already queued.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write all four registers once the block is idle.
   task automatic load_settings(input int deb, input int lp, input logic lpe,
                                input logic rpe);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_DEBOUNCE_TICKS;
      csr_wdata <= 16'(deb);
      @(posedge clock);
      csr_index <= CSR_LONG_PRESS_TICKS;
      csr_wdata <= 16'(lp);
      @(posedge clock);
      // upper bits of the enable writes are random and must be ignored
      csr_index <= CSR_LONG_PRESS_ENABLE;
      csr_wdata <= {15'($urandom), lpe};
      @(posedge clock);
      csr_index <= CSR_REPEAT_ENABLE;
      csr_wdata <= {15'($urandom), rpe};
      @(posedge clock);
      csr_we <= 1'b0;
      cur_debounce   = deb;
      cur_long_ticks = lp;
   endtask

   task automatic set_pace(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 55; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 55; end
         default: begin send_idle_pct = 25; rsp_stall_pct = 25; end
      endcase
   endtask

   // Mostly alternating press and release runs sized around the debounce
   // and long-press boundaries, with some bursts of random chatter.
   task automatic drive_presses(input int n_items);
      int   sent;
      int   run;
      int   k;
      logic lvl;
      sent = 0;
      lvl  = 1'b0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            run = $urandom_range(1, 6);
            for (k = 0; k < run && sent < n_items; k++) begin
               send_sample(1'($urandom_range(1)), 1'b0, EV_NONE, 1'b0);
               sent++;
            end
         end else begin
            lvl = ~lvl;
            case ($urandom_range(2))
               0: run = $urandom_range(1, cur_debounce + 1);
               1: run = cur_debounce + $urandom_range(1, 3);
               default: run = cur_debounce + 2 + (cur_long_ticks + 1) * $urandom_range(1, 3)
                              + $urandom_range(0, 2);
            endcase
            for (k = 0; k < run && sent < n_items; k++) begin
               send_sample(lvl, 1'b0, EV_NONE, 1'b0);
               sent++;
            end
         end
      end
   endtask

   // Directed rows, run with zero debounce and zero long-press ticks so that
   // every result can be traced by hand.
   typedef struct {
      logic      level;
      event_type ev;
      logic      held;
   } script_row;

   script_row script [SCRIPT_LEN] = '{
      '{1'b1, EV_NONE,       1'b0},  // start press debounce
      '{1'b1, EV_PRESS,      1'b1},
      '{1'b1, EV_LONG_PRESS, 1'b1},
      '{1'b1, EV_REPEAT,     1'b1},
      '{1'b1, EV_REPEAT,     1'b1},
      '{1'b0, EV_NONE,       1'b1},  // long release debounce
      '{1'b0, EV_LONG_REL,   1'b0},
      '{1'b0, EV_ENTER_REL,  1'b0},
      '{1'b1, EV_NONE,       1'b0},
      '{1'b0, EV_NONE,       1'b0},  // glitch aborts the press
      '{1'b1, EV_NONE,       1'b0},
      '{1'b1, EV_PRESS,      1'b1},
      '{1'b0, EV_NONE,       1'b1},
      '{1'b1, EV_NONE,       1'b1},  // bounce back to pressed
      '{1'b0, EV_NONE,       1'b1},
      '{1'b0, EV_RELEASE,    1'b0},
      '{1'b1, EV_ENTER_REL,  1'b0},  // entering released starts a press at once
      '{1'b1, EV_PRESS,      1'b1},
      '{1'b0, EV_NONE,       1'b1},
      '{1'b1, EV_NONE,       1'b1},
      '{1'b1, EV_LONG_PRESS, 1'b1},
      '{1'b0, EV_NONE,       1'b1},
      '{1'b1, EV_NONE,       1'b1},  // bounce back to long pressed
      '{1'b0, EV_NONE,       1'b1},
      '{1'b0, EV_LONG_REL,   1'b0}
   };

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int p;
      int i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      load_settings(0, 0, 1'b1, 1'b1);
      set_pace(0);
      for (i = 0; i < SCRIPT_LEN; i++)
         send_sample(script[i].level, 1'b1, script[i].ev, script[i].held);

      for (p = 1; p <= 12; p++) begin
         case (p)
            1:  load_settings(20, 1000, 1'b1, 1'b1);   // reset defaults
            2:  load_settings(0, 0, 1'b1, 1'b1);
            3:  load_settings(3, 8, 1'b1, 1'b1);
            4:  load_settings(2, 5, 1'b0, 1'b1);       // long press off
            5:  load_settings(4, 10, 1'b1, 1'b0);      // repeat off
            6:  load_settings(65535, 65535, 1'b1, 1'b1);
            7:  load_settings(1, 3, 1'b1, 1'b1);
            8:  load_settings(1, 2, 1'b0, 1'b0);
            default: load_settings($urandom_range(0, 6), $urandom_range(0, 12),
                                   1'($urandom_range(1)), 1'($urandom_range(1)));
         endcase
         set_pace(p % 4);
         if (p == 5) begin
            // hold the result side off while samples keep coming
            set_pace(0);
            hold_left = 300;
            drive_presses(PHASE_ITEMS);
         end else if (p == 6) begin
            drive_presses(HUGE_ITEMS);
         end else if (p == 7) begin
            // pause the sample side mid-sequence until all results are in
            drive_presses(PHASE_ITEMS / 2);
            wait_drained();
            drive_presses(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            drive_presses(PHASE_ITEMS);
         end
      end

      set_pace(0);
      wait_drained();
      repeat (3) @(posedge clock);
      if (fail_count == 0)
         $display("** button_debounce_longpress_fsm: PASSED **");
      else
         $display("** button_debounce_longpress_fsm: FAILED **");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/bdlp_pkg.sv
src/bdlp_core.sv
src/bdlp_rsp_queue.sv
src/button_debounce_longpress_fsm.sv
tb/button_debounce_longpress_fsm_tb.sv
